// ===== rtl/tmps_pkg.sv =====
// Shared types and constants of the triangle maximum path sum core.
// No dependencies; every other file but tmps_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tmps_pkg;

    localparam int SUM_W = 21;
    localparam int CFG_W = 6;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 21'h0FFFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 21'h100000;

    localparam logic KIND_SUM  = 1'b0;
    localparam logic KIND_PATH = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_BASE,
        ST_UP,
        ST_PSUM,
        ST_PEMIT,
        ST_PAPEX,
        ST_PSTEP
    } t_state;

    typedef enum logic [1:0] {
        OP_BASE,
        OP_CELL,
        OP_PATH
    } t_op;

endpackage

`default_nettype wire

// ===== rtl/tmps_ram.sv =====
// Synchronous RAM, one write port and two registered read ports.
// Depends on nothing; used for the entry store and the best sum store.
`timescale 1ns / 1ps
`default_nettype none

module tmps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 528
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]                         o_rdata_a,
    output logic      [WIDTH-1:0]                         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/tmps_calc.sv =====
// Better child plus entry (base, path: entry alone); saturate to sum range.
// Depends on tmps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmps_calc
    import tmps_pkg::*;
#(
    parameter int ENTRY_WIDTH = 16
) (
    input  wire t_op                           i_op,
    input  wire logic        [ENTRY_WIDTH-1:0] i_entry_a,
    input  wire logic        [ENTRY_WIDTH-1:0] i_entry_b,
    input  wire logic signed [SUM_W-1:0]       i_down,
    input  wire logic signed [SUM_W-1:0]       i_right,
    output logic signed      [SUM_W-1:0]       o_value,
    output logic                               o_take_right
);

    localparam int XW = ((ENTRY_WIDTH > SUM_W) ? ENTRY_WIDTH : SUM_W) + 2;

    logic signed [SUM_W-1:0]       best;
    logic        [ENTRY_WIDTH-1:0] ent;
    logic signed [XW-1:0]          ent_x;
    logic signed [XW-1:0]          best_x;
    logic signed [XW-1:0]          sum_x;
    logic signed [XW-1:0]          hi_x;
    logic signed [XW-1:0]          lo_x;

    // tie goes down-right
    assign o_take_right = (i_right >= i_down);
    assign best         = o_take_right ? i_right : i_down;

    always_comb begin
        case (i_op)
            OP_BASE: begin
                ent    = i_entry_a;
                best_x = '0;
            end
            OP_CELL: begin
                ent    = i_entry_a;
                best_x = {{(XW-SUM_W){best[SUM_W-1]}}, best};
            end
            OP_PATH: begin
                ent    = o_take_right ? i_entry_b : i_entry_a;
                best_x = '0;
            end
            default: begin
                ent    = i_entry_a;
                best_x = '0;
            end
        endcase
    end

    assign ent_x = {{(XW-ENTRY_WIDTH){ent[ENTRY_WIDTH-1]}}, ent};
    assign sum_x = ent_x + best_x;
    assign hi_x  = {{(XW-SUM_W){1'b0}}, SUM_MAX};
    assign lo_x  = {{(XW-SUM_W){1'b1}}, SUM_MIN};

    always_comb begin
        if (sum_x > hi_x) begin
            o_value = SUM_MAX;
        end else if (sum_x < lo_x) begin
            o_value = SUM_MIN;
        end else begin
            o_value = sum_x[SUM_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/triangle_max_path_sum_core.sv =====
// Busy after the last entry until the results are out; a triangle has total entries,
//   total = rows*(rows+1)/2; results come one per cycle, sum first, then rows path values.
// Throughput: one entry per cycle while loading; the sweep updates one cell per cycle,
//   holding while a child is being written back; both children are read on two RAM ports.
// Reset: synchronous, active low; row count returns to 1, load count and path column to 0.
//   RAM contents are not cleared; every cell is written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module triangle_max_path_sum_core
    import tmps_pkg::*;
#(
    parameter int MAX_ROWS    = 32,
    parameter int ENTRY_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic signed [ENTRY_WIDTH-1:0] i_entry_value,
    output logic                               busy,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic        [CFG_W-1:0]       i_cfg_wr_data,
    output logic                               o_result_strobe,
    output logic                               o_result_kind,
    output logic signed      [SUM_W-1:0]       o_result_value,
    output logic                               o_last_result
);

    // Store geometry: a triangle of MAX_ROWS rows laid out row-major.
    localparam int SD = MAX_ROWS * (MAX_ROWS + 1) / 2;
    localparam int AW = (SD > 1) ? $clog2(SD) : 1;
    localparam int CW = $clog2(SD + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                  r_state,     n_state;
    logic [CFG_W-1:0]        r_row_cnt;
    logic [CW-1:0]           r_load_cnt,  n_load_cnt;
    logic [RW-1:0]           r_rows,      n_rows;
    logic [RW-1:0]           r_row,       n_row;
    logic [RW-1:0]           r_col,       n_col;
    logic [RW-1:0]           r_pc,        n_pc;
    logic [AW-1:0]           r_addr,      n_addr;
    logic [AW-1:0]           r_row_start, n_row_start;

    // write-back stage: one cell update in flight toward the best sum RAM
    logic                    r_s2_valid,  n_s2_valid;
    t_op                     r_s2_op,     n_s2_op;
    logic [AW-1:0]           r_s2_waddr,  n_s2_waddr;

    logic                    r_out_stb,   n_out_stb;
    logic                    r_out_kind,  n_out_kind;
    logic signed [SUM_W-1:0] r_out_value, n_out_value;
    logic                    r_out_last,  n_out_last;

    // ------------------------------------------------------------------
    // Memory ports and datapath wires
    // ------------------------------------------------------------------
    logic                    ent_we;
    logic [AW-1:0]           ent_ra, ent_rb;
    logic [ENTRY_WIDTH-1:0]  ent_qa, ent_qb;
    logic [AW-1:0]           sum_ra, sum_rb;
    logic signed [SUM_W-1:0] sum_qa, sum_qb;
    logic signed [SUM_W-1:0] calc_value;
    logic                    take_right;
    t_op                     calc_op;

    // ------------------------------------------------------------------
    // Row count clamp and triangle size
    // ------------------------------------------------------------------
    logic [RW-1:0]           rows_now;
    logic [CW:0]             rows_prod;
    logic [CW-1:0]           total_now;
    logic [CW-1:0]           load_next;

    always_comb begin
        if (r_row_cnt == '0) begin
            rows_now = RW'(1);
        end else if (r_row_cnt > CFG_W'(MAX_ROWS)) begin
            rows_now = RW'(MAX_ROWS);
        end else begin
            rows_now = RW'(r_row_cnt);
        end
    end

    assign rows_prod = (CW+1)'(rows_now) * ((CW+1)'(rows_now) + (CW+1)'(1));
    assign total_now = rows_prod[CW:1];
    assign load_next = r_load_cnt + CW'(1);

    // Sweep addresses: children of cell (row, c) sit row+1 and row+2 places later.
    logic [AW-1:0] up_ra, up_rb;
    logic          up_hazard;

    assign up_ra     = AW'(r_addr + AW'(r_row) + AW'(1));
    assign up_rb     = AW'(up_ra + AW'(1));
    assign up_hazard = r_s2_valid && ((r_s2_waddr == up_ra) || (r_s2_waddr == up_rb));

    // Path walk addresses for the next row, from the column just chosen.
    logic [RW-1:0] path_pc;
    logic [AW-1:0] path_start;
    logic [AW-1:0] path_ra, path_rb;
    logic          path_last;

    assign path_pc    = r_pc + RW'(take_right);
    assign path_start = AW'(r_row_start + AW'(r_row) + AW'(1));
    assign path_ra    = AW'(path_start + AW'(path_pc));
    assign path_rb    = AW'(path_ra + AW'(1));
    assign path_last  = (r_row == r_rows - RW'(1));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_load_cnt  = r_load_cnt;
        n_rows      = r_rows;
        n_row       = r_row;
        n_col       = r_col;
        n_pc        = r_pc;
        n_addr      = r_addr;
        n_row_start = r_row_start;
        n_s2_valid  = 1'b0;
        n_s2_op     = OP_BASE;
        n_s2_waddr  = r_addr;
        n_out_stb   = 1'b0;
        n_out_kind  = KIND_PATH;
        n_out_value = calc_value;
        n_out_last  = 1'b0;
        ent_we      = 1'b0;
        ent_ra      = r_addr;
        ent_rb      = r_addr;
        sum_ra      = r_addr;
        sum_rb      = r_addr;

        case (r_state)
            ST_LOAD: begin
                // store each request; the one that fills the triangle starts the sweep
                ent_we = start;
                if (start) begin
                    if (load_next >= total_now) begin
                        n_load_cnt  = '0;
                        n_rows      = rows_now;
                        n_addr      = AW'(total_now - CW'(rows_now));
                        n_row_start = AW'(total_now - CW'(rows_now));
                        n_col       = '0;
                        n_state     = ST_BASE;
                    end else begin
                        n_load_cnt = load_next;
                    end
                end
            end

            ST_BASE: begin
                // base row: best sum is the saturated entry itself
                ent_ra     = r_addr;
                n_s2_valid = 1'b1;
                n_s2_op    = OP_BASE;
                n_s2_waddr = r_addr;
                n_addr     = AW'(r_addr + AW'(1));
                n_col      = r_col + RW'(1);
                if (r_col == r_rows - RW'(1)) begin
                    if (r_rows == RW'(1)) begin
                        n_state = ST_PSUM;
                    end else begin
                        n_row       = r_rows - RW'(2);
                        n_row_start = AW'(r_row_start - AW'(r_rows - RW'(1)));
                        n_addr      = AW'(r_row_start - AW'(r_rows - RW'(1)));
                        n_col       = '0;
                        n_state     = ST_UP;
                    end
                end
            end

            ST_UP: begin
                // one cell per cycle; hold while a child is still being written back
                ent_ra = r_addr;
                sum_ra = up_ra;
                sum_rb = up_rb;
                if (!up_hazard) begin
                    n_s2_valid = 1'b1;
                    n_s2_op    = OP_CELL;
                    n_s2_waddr = r_addr;
                    if (r_col == r_row) begin
                        if (r_row == '0) begin
                            n_state = ST_PSUM;
                        end else begin
                            n_row       = r_row - RW'(1);
                            n_row_start = AW'(r_row_start - AW'(r_row));
                            n_addr      = AW'(r_row_start - AW'(r_row));
                            n_col       = '0;
                        end
                    end else begin
                        n_addr = AW'(r_addr + AW'(1));
                        n_col  = r_col + RW'(1);
                    end
                end
            end

            ST_PSUM: begin
                // read the apex once its last update has landed
                ent_ra = '0;
                sum_ra = '0;
                sum_rb = '0;
                if (!(r_s2_valid && (r_s2_waddr == '0))) begin
                    n_state = ST_PEMIT;
                end
            end

            ST_PEMIT: begin
                ent_ra      = '0;
                n_out_stb   = 1'b1;
                n_out_kind  = KIND_SUM;
                n_out_value = sum_qa;
                n_state     = ST_PAPEX;
            end

            ST_PAPEX: begin
                n_out_stb   = 1'b1;
                n_out_kind  = KIND_PATH;
                n_out_last  = (r_rows == RW'(1));
                n_pc        = '0;
                if (r_rows == RW'(1)) begin
                    n_state = ST_LOAD;
                end else begin
                    // row 1 starts at address 1
                    ent_ra      = AW'(1);
                    ent_rb      = AW'(2);
                    sum_ra      = AW'(1);
                    sum_rb      = AW'(2);
                    n_row       = RW'(1);
                    n_row_start = AW'(1);
                    n_state     = ST_PSTEP;
                end
            end

            ST_PSTEP: begin
                // step down or down-right, emit the entry, fetch the next row
                n_out_stb  = 1'b1;
                n_out_kind = KIND_PATH;
                n_out_last = path_last;
                n_pc       = path_pc;
                if (path_last) begin
                    n_state = ST_LOAD;
                end else begin
                    ent_ra      = path_ra;
                    ent_rb      = path_rb;
                    sum_ra      = path_ra;
                    sum_rb      = path_rb;
                    n_row       = r_row + RW'(1);
                    n_row_start = path_start;
                end
            end

            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        if (r_s2_valid) begin
            calc_op = r_s2_op;
        end else if (r_state == ST_PSTEP) begin
            calc_op = OP_PATH;
        end else begin
            calc_op = OP_BASE;
        end
    end

    // ------------------------------------------------------------------
    // Clocked state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_row_cnt  <= CFG_W'(1);
            r_load_cnt <= '0;
            r_pc       <= '0;
            r_s2_valid <= 1'b0;
            r_out_stb  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_pc       <= n_pc;
            r_s2_valid <= n_s2_valid;
            r_out_stb  <= n_out_stb;
            if (i_cfg_wr_en) begin
                r_row_cnt <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rows      <= n_rows;
        r_row       <= n_row;
        r_col       <= n_col;
        r_addr      <= n_addr;
        r_row_start <= n_row_start;
        r_s2_op     <= n_s2_op;
        r_s2_waddr  <= n_s2_waddr;
        r_out_kind  <= n_out_kind;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    // ------------------------------------------------------------------
    // Stores and cell update
    // ------------------------------------------------------------------
    tmps_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (SD)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_we      (ent_we),
        .i_waddr   (r_load_cnt[AW-1:0]),
        .i_wdata   (i_entry_value),
        .i_raddr_a (ent_ra),
        .i_raddr_b (ent_rb),
        .o_rdata_a (ent_qa),
        .o_rdata_b (ent_qb)
    );

    tmps_ram #(
        .WIDTH (SUM_W),
        .DEPTH (SD)
    ) u_sum_ram (
        .i_clk     (i_clk),
        .i_we      (r_s2_valid),
        .i_waddr   (r_s2_waddr),
        .i_wdata   (calc_value),
        .i_raddr_a (sum_ra),
        .i_raddr_b (sum_rb),
        .o_rdata_a (sum_qa),
        .o_rdata_b (sum_qb)
    );

    tmps_calc #(
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_calc (
        .i_op         (calc_op),
        .i_entry_a    (ent_qa),
        .i_entry_b    (ent_qb),
        .i_down       (sum_qa),
        .i_right      (sum_qb),
        .o_value      (calc_value),
        .o_take_right (take_right)
    );

    assign busy            = (r_state != ST_LOAD);
    assign o_result_strobe = r_out_stb;
    assign o_result_kind   = r_out_kind;
    assign o_result_value  = r_out_value;
    assign o_last_result   = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/tmps_checker.sv =====
// Port-level checks on the result stream of the triangle core, bound to the top level.
// Depends on tmps_pkg and triangle_max_path_sum_core.
`timescale 1ns / 1ps
`default_nettype none

module tmps_core_props
    import tmps_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_busy,
    input wire logic i_result_strobe,
    input wire logic i_result_kind,
    input wire logic i_last_result
);

    // only the closing path value may show once the core is idle again
    a_busy_during_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_strobe && !i_last_result |-> i_busy)
        else $error("result shown while core idle");

    a_last_is_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_last_result |-> i_result_strobe && (i_result_kind == KIND_PATH))
        else $error("last flag outside a path result");

    a_apex_follows_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_strobe && (i_result_kind == KIND_SUM)
        |=> i_result_strobe && (i_result_kind == KIND_PATH))
        else $error("apex value does not follow the sum");

    a_path_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_strobe && (i_result_kind == KIND_PATH) && !i_last_result
        |=> i_result_strobe && (i_result_kind == KIND_PATH))
        else $error("path stream broken before its last value");

endmodule

bind triangle_max_path_sum_core tmps_core_props u_tmps_core_props (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_busy          (busy),
    .i_result_strobe (o_result_strobe),
    .i_result_kind   (o_result_kind),
    .i_last_result   (o_last_result)
);

`default_nettype wire

// ===== test/tmps_checker.sv =====
// Checker for the triangle maximum path sum core: it predicts and compares every result.
// Depends on tmps_pkg; the testbench top instantiates it beside the core.
`timescale 1ns / 1ps

module tmps_checker
    import tmps_pkg::*;
#(
    parameter int MAX_ROWS    = 32,
    parameter int ENTRY_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_busy,
    input  wire logic signed [ENTRY_WIDTH-1:0] i_entry_value,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic        [CFG_W-1:0]       i_cfg_wr_data,
    input  wire logic                          i_result_strobe,
    input  wire logic                          i_result_kind,
    input  wire logic signed [SUM_W-1:0]       i_result_value,
    input  wire logic                          i_last_result,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked
);

    localparam int DEPTH = MAX_ROWS * (MAX_ROWS + 1) / 2;

    typedef struct packed {
        logic                    kind;
        logic signed [SUM_W-1:0] value;
        logic                    last;
    } t_path_item;

    int               tri_entries [DEPTH];
    int               best_sums   [DEPTH];
    int               entries_loaded = 0;
    logic [CFG_W-1:0] row_setting = 6'd1;
    t_path_item       due_items [$];
    t_path_item       due;
    int               errors = 0;
    int               checked = 0;

    function automatic logic signed [SUM_W-1:0] clamp_sum(input longint s);
        if (s > longint'(SUM_MAX)) return SUM_MAX;
        if (s < longint'(SUM_MIN)) return SUM_MIN;
        return s[SUM_W-1:0];
    endfunction

    function automatic int slot(input int r, input int c);
        int i;
        i = r * (r + 1) / 2 + c;
        return (i < DEPTH) ? i : 0;
    endfunction

    function automatic int active_rows();
        int r;
        r = int'(row_setting);
        if (r < 1) r = 1;
        if (r > MAX_ROWS) r = MAX_ROWS;
        return r;
    endfunction

    // Store one entry; on the last entry of the triangle fold it bottom-up and
    // queue the sum followed by the path values (ties go down-right).
    task automatic absorb_entry(input int entry);
        int     rows;
        int     total;
        int     col;
        longint down_sum;
        longint right_sum;
        rows  = active_rows();
        total = rows * (rows + 1) / 2;
        if (entries_loaded < DEPTH) tri_entries[entries_loaded] = entry;
        entries_loaded++;
        if (entries_loaded < total) return;
        entries_loaded = 0;

        for (int c = 0; c < rows; c++)
            best_sums[slot(rows - 1, c)] = clamp_sum(tri_entries[slot(rows - 1, c)]);
        for (int r = rows - 1; r > 0; r--) begin
            for (int c = 0; c < r; c++) begin
                down_sum  = best_sums[slot(r, c)];
                right_sum = best_sums[slot(r, c + 1)];
                best_sums[slot(r - 1, c)] = clamp_sum(longint'(tri_entries[slot(r - 1, c)])
                    + ((right_sum >= down_sum) ? right_sum : down_sum));
            end
        end

        due_items.push_back('{KIND_SUM, clamp_sum(best_sums[0]), 1'b0});
        col = 0;
        due_items.push_back('{KIND_PATH, clamp_sum(tri_entries[0]), rows == 1});
        for (int r = 1; r < rows; r++) begin
            if (best_sums[slot(r, col + 1)] >= best_sums[slot(r, col)]) col++;
            due_items.push_back('{KIND_PATH, clamp_sum(tri_entries[slot(r, col)]),
                                  r == rows - 1});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entries_loaded = 0;
            row_setting    = 6'd1;
            due_items.delete();
        end else begin
            // check the result first: it belongs to an older request
            if (i_result_strobe) begin
                checked++;
                if (due_items.size() == 0) begin
                    $error("unexpected result: kind %0d value %0d last %0d",
                           i_result_kind, i_result_value, i_last_result);
                    errors++;
                end else begin
                    due = due_items.pop_front();
                    if (i_result_kind !== due.kind) begin
                        $error("result_kind: expected %0d, got %0d", due.kind, i_result_kind);
                        errors++;
                    end
                    if (i_result_value !== due.value) begin
                        $error("result_value: expected %0d, got %0d",
                               due.value, i_result_value);
                        errors++;
                    end
                    if (i_last_result !== due.last) begin
                        $error("last_result: expected %0d, got %0d", due.last, i_last_result);
                        errors++;
                    end
                end
            end
            // a request on the same edge as a register write still sees the old row count
            if (i_start && !i_busy) absorb_entry(int'(i_entry_value));
            if (i_cfg_wr_en) row_setting = i_cfg_wr_data;
        end
        o_fail_count <= errors;
        o_pending    <= due_items.size();
        o_checked    <= checked;
    end

endmodule

// ===== test/testbench.sv =====
// Top of the triangle maximum path sum testbench: clock, reset, stimulus and verdict.
// Depends on tmps_pkg, triangle_max_path_sum_core and tmps_checker.
`timescale 1ns / 1ps

module testbench;
    import tmps_pkg::*;

    localparam int MAX_ROWS    = 32;
    localparam int ENTRY_W     = 16;
    localparam int CYCLE_LIMIT = 400_000;
    // random requests per idle phase; with the directed part about 330 in all
    localparam int PHASE_ITEMS = 50;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic signed [ENTRY_W-1:0] i_entry_value = '0;
    logic                      i_cfg_wr_en = 1'b0;
    logic        [CFG_W-1:0]   i_cfg_wr_data = '0;
    logic                      busy;
    logic                      o_result_strobe;
    logic                      o_result_kind;
    logic signed [SUM_W-1:0]   o_result_value;
    logic                      o_last_result;

    int               fail_count;
    int               pending_results;
    int               results_checked;
    int               cycle_count = 0;
    int               entries_sent = 0;
    int               idle_pct = 0;
    logic [CFG_W-1:0] row_setting = 6'd1;   // mirrors the register, reset value 1

    triangle_max_path_sum_core #(
        .MAX_ROWS   (MAX_ROWS),
        .ENTRY_WIDTH(ENTRY_W)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_entry_value  (i_entry_value),
        .busy           (busy),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_result_strobe(o_result_strobe),
        .o_result_kind  (o_result_kind),
        .o_result_value (o_result_value),
        .o_last_result  (o_last_result)
    );

    tmps_checker #(
        .MAX_ROWS   (MAX_ROWS),
        .ENTRY_WIDTH(ENTRY_W)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_entry_value  (i_entry_value),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_result_strobe(o_result_strobe),
        .i_result_kind  (o_result_kind),
        .i_result_value (o_result_value),
        .i_last_result  (o_last_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending_results),
        .o_checked      (results_checked)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: a hung core or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("triangle_max_path_sum_core test failed");
            $finish;
        end
    end

    // Number of entries in one triangle for a given register value,
    // with the core's clamping of 0 and of values above MAX_ROWS.
    function automatic int triangle_size(input logic [CFG_W-1:0] setting);
        int r;
        r = int'(setting);
        if (r < 1) r = 1;
        if (r > MAX_ROWS) r = MAX_ROWS;
        return r * (r + 1) / 2;
    endfunction

    // Random entry: extremes, small values that make ties likely, or any 16-bit word.
    function automatic logic signed [ENTRY_W-1:0] random_entry();
        int small_val;
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3: begin
                small_val = $urandom_range(16);
                return ENTRY_W'(small_val - 8);
            end
            default: return ENTRY_W'($urandom);
        endcase
    endfunction

    // Present one request and hold it until the core takes it. Idle cycles go
    // in front of it at the current idle rate; start drops only during them.
    task automatic send_entry(input logic signed [ENTRY_W-1:0] entry);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start         = 1'b1;
        i_entry_value = entry;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        entries_sent++;
    endtask

    // Drop start and wait until every expected result has come and the core
    // is idle, then give it a few cycles more.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        @(posedge i_clk);
        while (pending_results != 0 || busy) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Write the row count while the core is idle.
    task automatic write_rows(input logic [CFG_W-1:0] rows);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = rows;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        row_setting   = rows;
    endtask

    // Send a whole triangle of random entries at the current row count.
    task automatic send_random_triangle(output int sent);
        sent = triangle_size(row_setting);
        for (int i = 0; i < sent; i++) send_entry(random_entry());
    endtask

    initial begin
        int phase_sent;
        int tri_sent;
        int rand_rows;
        int idle_levels [3];
        idle_levels = '{0, 73, 33};

        // Hold reset and release it on a falling edge.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, no idling.
        // One-row triangles at the reset row count: the extremes of an entry.
        send_entry(16'sh7FFF);
        send_entry(16'sh8000);
        // A row count of zero acts as one row.
        write_rows(6'd0);
        send_entry(16'sd0);
        // Two rows: the larger base cell wins.
        write_rows(6'd2);
        send_entry(16'sd100);
        send_entry(-16'sd5);
        send_entry(16'sd3);
        // Three rows with equal sums below the apex: the path must go down-right.
        write_rows(6'd3);
        send_entry(16'sd0);
        send_entry(16'sd1);
        send_entry(16'sd2);
        send_entry(16'sd4);
        send_entry(16'sd3);
        send_entry(16'sd2);
        // Row count changed part way through a load: finish at the new size.
        write_rows(6'd4);
        send_entry(16'sd11);
        send_entry(16'sd12);
        write_rows(6'd3);
        send_entry(16'sd13);
        send_entry(-16'sd14);
        send_entry(16'sd15);
        send_entry(16'sd16);
        // Two rows of extreme values.
        write_rows(6'd2);
        send_entry(16'sh7FFF);
        send_entry(16'sh8000);
        send_entry(16'sh7FFF);

        // Sixteen rows all at the positive extreme: the largest sums of the run.
        write_rows(6'd16);
        for (int i = 0; i < triangle_size(row_setting); i++) send_entry(16'sh7FFF);

        // Random part: mostly small triangles; about a third go back to back
        // with the same row count, so start meets a busy core.
        foreach (idle_levels[p]) begin
            idle_pct   = idle_levels[p];
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS) begin
                if ($urandom_range(2) != 0) begin
                    rand_rows = ($urandom_range(9) == 0) ? $urandom_range(16)
                                                         : $urandom_range(1, 6);
                    write_rows(6'(rand_rows));
                end
                send_random_triangle(tri_sent);
                phase_sent += tri_sent;
            end
        end

        // Wait for the last results, then watch for stray ones.
        drain();
        repeat (40) @(posedge i_clk);

        $display("Covered %0d entries and %0d results: row counts 0 to 16, ties, a row change",
                 entries_sent, results_checked);
        $display("during a load, a deep triangle of extremes, sender idle of 0, 33 and 73 pct.");
        if (fail_count == 0) begin
            $display("triangle_max_path_sum_core test passed");
        end else begin
            $display("triangle_max_path_sum_core test failed");
        end
        $finish;
    end

endmodule

// ===== triangle_max_path_sum_core.f =====
rtl/tmps_pkg.sv
rtl/tmps_ram.sv
rtl/tmps_calc.sv
rtl/triangle_max_path_sum_core.sv
rtl/tmps_checker.sv
test/tmps_checker.sv
test/testbench.sv
